[rtl/glr_pkg.sv]
package glr_pkg;

	localparam int MAX_SPAN     = 64;
	localparam int COORD_BITS   = 11;
	localparam int PIX_BITS     = 12;
	localparam int OFFSET_BITS  = 11;
	localparam int CHAN_BITS    = 8;
	localparam int NUM_CHAN     = 3;
	localparam int COLOR_BITS   = CHAN_BITS * NUM_CHAN;
	localparam int CNT_BITS     = $clog2(MAX_SPAN + 1);
	// Room for the start value plus one increment per emitted pixel, with sign.
	localparam int ERR_BITS     = COORD_BITS + CNT_BITS + 3;
	localparam int DIV_STEPS    = CHAN_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_FLAT_COLOR   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RAISED_COLOR = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_OFFSET = 2'd2;

	localparam logic OP_X_MAJOR = 1'b0;
	localparam logic OP_Y_MAJOR = 1'b1;

	localparam logic [COLOR_BITS-1:0]  FLAT_COLOR_RESET   = 24'hFFFFFF;
	localparam logic [COLOR_BITS-1:0]  RAISED_COLOR_RESET = 24'h8B0000;
	localparam logic [OFFSET_BITS-1:0] PIXEL_OFFSET_RESET = 11'd100;

	typedef struct packed {
		logic                  opcode;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
		logic                  start_raised;
		logic                  end_raised;
	} segment_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]   pixel_x;
		logic [PIX_BITS-1:0]   pixel_y;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  last_pixel;
	} pixel_t;

	// Per channel blend: value = base +/- floor(mag * k / span), walked as
	// quotient qd and remainder rd of mag / span.
	typedef struct packed {
		logic [CHAN_BITS-1:0]  base;
		logic                  neg;
		logic [CHAN_BITS-1:0]  qd;
		logic [COORD_BITS-1:0] rd;
	} chan_t;

	typedef struct packed {
		logic                       steep;
		logic [COORD_BITS-1:0]      major;
		logic [COORD_BITS-1:0]      minor;
		logic signed [ERR_BITS-1:0] err;
		logic signed [ERR_BITS-1:0] inc_lt;
		logic signed [ERR_BITS-1:0] inc_ge;
		logic [CNT_BITS-1:0]        count;
		logic [COORD_BITS-1:0]      span;
		chan_t [NUM_CHAN-1:0]       chan;
	} job_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIV,
		FE_PUSH
	} front_state_t;

endpackage

[rtl/glr_front.sv]
module glr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  glr_pkg::segment_t               segment,
	input  logic [glr_pkg::COLOR_BITS-1:0]  flat_color,
	input  logic [glr_pkg::COLOR_BITS-1:0]  raised_color,
	input  logic                            q_full,
	output logic                            q_wr,
	output glr_pkg::job_t                   q_job
);
	import glr_pkg::*;

	front_state_t state_q, state_d;
	logic [DIV_CNT_BITS-1:0] div_cnt_q, div_cnt_d;
	job_t job_q, job_d;
	logic [CHAN_BITS-1:0]  num_q [NUM_CHAN];
	logic [CHAN_BITS-1:0]  num_d [NUM_CHAN];
	logic [COORD_BITS-1:0] rem_q [NUM_CHAN];
	logic [COORD_BITS-1:0] rem_d [NUM_CHAN];

	logic                         accept;
	logic                         steep;
	logic [COORD_BITS-1:0]        smaj, emaj, smin, emin;
	logic signed [COORD_BITS:0]   dmaj, dmin;
	logic signed [ERR_BITS-1:0]   dmaj_e, dmin_e;
	logic [COLOR_BITS-1:0]        cs, ce;
	logic [CHAN_BITS-1:0]         ca, cb;
	logic [COORD_BITS:0]          trial;
	logic                         fits;

	assign accept = push && !full;
	assign full   = (state_q != FE_IDLE);
	assign q_wr   = (state_q == FE_PUSH) && !q_full;

	always_comb begin
		q_job = job_q;
		for (int c = 0; c < NUM_CHAN; c++) begin
			q_job.chan[c].qd = num_q[c];
			q_job.chan[c].rd = rem_q[c];
		end
	end

	// Segment setup, taken straight from the input item.
	always_comb begin
		steep  = (segment.opcode == OP_Y_MAJOR);
		smaj   = steep ? segment.start_y : segment.start_x;
		emaj   = steep ? segment.end_y   : segment.end_x;
		smin   = steep ? segment.start_x : segment.start_y;
		emin   = steep ? segment.end_x   : segment.end_y;
		dmaj   = signed'({1'b0, emaj}) - signed'({1'b0, smaj});
		dmin   = signed'({1'b0, emin}) - signed'({1'b0, smin});
		dmaj_e = ERR_BITS'(dmaj);
		dmin_e = ERR_BITS'(dmin);
		cs     = segment.start_raised ? raised_color : flat_color;
		ce     = segment.end_raised   ? raised_color : flat_color;
	end

	always_comb begin
		state_d   = state_q;
		div_cnt_d = div_cnt_q;
		job_d     = job_q;
		ca        = '0;
		cb        = '0;
		trial     = '0;
		fits      = 1'b0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			num_d[c] = num_q[c];
			rem_d[c] = rem_q[c];
		end
		case (state_q)
			FE_IDLE: begin
				if (accept) begin
					job_d.steep  = steep;
					job_d.major  = smaj;
					job_d.minor  = smin;
					job_d.err    = (dmin_e <<< 1) - dmaj_e;
					job_d.inc_lt = dmin_e <<< 1;
					job_d.inc_ge = (dmin_e - dmaj_e) <<< 1;
					job_d.count  = (dmaj >= MAX_SPAN) ? CNT_BITS'(MAX_SPAN) : CNT_BITS'(dmaj);
					job_d.span   = dmaj[COORD_BITS-1:0];
					for (int c = 0; c < NUM_CHAN; c++) begin
						ca = cs[c*CHAN_BITS +: CHAN_BITS];
						cb = ce[c*CHAN_BITS +: CHAN_BITS];
						job_d.chan[c].base = ca;
						job_d.chan[c].neg  = (cb < ca);
						job_d.chan[c].qd   = '0;
						job_d.chan[c].rd   = '0;
						num_d[c] = (cb < ca) ? (ca - cb) : (cb - ca);
						rem_d[c] = '0;
					end
					div_cnt_d = '0;
					// A segment that does not advance along its major axis draws nothing.
					if (dmaj > 0) begin
						state_d = FE_DIV;
					end
				end
			end
			FE_DIV: begin
				// Restoring division, one quotient bit per cycle; the quotient
				// shifts into the numerator register.
				for (int c = 0; c < NUM_CHAN; c++) begin
					trial    = {rem_q[c], num_q[c][CHAN_BITS-1]};
					fits     = (trial >= {1'b0, job_q.span});
					rem_d[c] = fits ? COORD_BITS'(trial - {1'b0, job_q.span})
					                : trial[COORD_BITS-1:0];
					num_d[c] = {num_q[c][CHAN_BITS-2:0], fits};
				end
				div_cnt_d = div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
					state_d = FE_PUSH;
				end
			end
			FE_PUSH: begin
				if (!q_full) begin
					state_d = FE_IDLE;
				end
			end
			default: begin
				state_d = FE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FE_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		job_q <= job_d;
		for (int c = 0; c < NUM_CHAN; c++) begin
			num_q[c] <= num_d[c];
			rem_q[c] <= rem_d[c];
		end
	end

endmodule

[rtl/glr_queue.sv]
module glr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  glr_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd,
	output glr_pkg::job_t rd_job,
	output logic          empty
);
	import glr_pkg::*;

	job_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] fill_q;
	logic                 do_wr, do_rd;

	assign full   = (fill_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty  = (fill_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

[rtl/glr_back.sv]
module glr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	output logic                             q_rd,
	input  glr_pkg::job_t                    q_job,
	input  logic [glr_pkg::OFFSET_BITS-1:0]  pixel_offset,
	output logic                             empty,
	input  logic                             pop,
	output glr_pkg::pixel_t                  pixel
);
	import glr_pkg::*;

	job_t                       job_q;
	logic                       active_q;
	logic [CNT_BITS-1:0]        remaining_q;
	logic [COORD_BITS-1:0]      major_q, minor_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [CHAN_BITS-1:0]       acc_q  [NUM_CHAN];
	logic [COORD_BITS-1:0]      frac_q [NUM_CHAN];
	logic [CHAN_BITS-1:0]       acc_d  [NUM_CHAN];
	logic [COORD_BITS-1:0]      frac_d [NUM_CHAN];
	logic                       out_valid_q;
	pixel_t                     pixel_q, pixel_d;

	logic                  load, emit, last;
	logic [COORD_BITS-1:0] coord_x, coord_y;
	logic [COORD_BITS:0]   frac_sum;
	logic                  carry;
	logic                  frac_ok;

	assign load  = !active_q && !q_empty;
	assign q_rd  = load;
	assign emit  = active_q && (!out_valid_q || pop);
	assign last  = (remaining_q == CNT_BITS'(1));
	assign empty = !out_valid_q;
	assign pixel = pixel_q;

	always_comb begin
		coord_x  = job_q.steep ? minor_q : major_q;
		coord_y  = job_q.steep ? major_q : minor_q;
		frac_sum = '0;
		carry    = 1'b0;
		frac_ok  = 1'b1;
		pixel_d.pixel_x    = PIX_BITS'(coord_x) + PIX_BITS'(pixel_offset);
		pixel_d.pixel_y    = PIX_BITS'(coord_y) + PIX_BITS'(pixel_offset);
		pixel_d.last_pixel = last;
		pixel_d.pixel_color = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			pixel_d.pixel_color[c*CHAN_BITS +: CHAN_BITS] = job_q.chan[c].neg
				? (job_q.chan[c].base - acc_q[c])
				: (job_q.chan[c].base + acc_q[c]);
			// Advance floor(mag * k / span) by one k: add the quotient and
			// carry one more whenever the remainder wraps past the span.
			frac_sum  = {1'b0, frac_q[c]} + {1'b0, job_q.chan[c].rd};
			carry     = (frac_sum >= {1'b0, job_q.span});
			frac_d[c] = carry ? COORD_BITS'(frac_sum - {1'b0, job_q.span})
			                  : frac_sum[COORD_BITS-1:0];
			acc_d[c]  = acc_q[c] + job_q.chan[c].qd + CHAN_BITS'(carry);
			frac_ok   = frac_ok && (frac_q[c] < job_q.span);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			remaining_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q    <= 1'b1;
				remaining_q <= q_job.count;
			end else if (emit) begin
				remaining_q <= remaining_q - 1'b1;
				if (last) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q   <= q_job;
			major_q <= q_job.major;
			minor_q <= q_job.minor;
			err_q   <= q_job.err;
			for (int c = 0; c < NUM_CHAN; c++) begin
				acc_q[c]  <= '0;
				frac_q[c] <= '0;
			end
		end else if (emit) begin
			major_q <= major_q + 1'b1;
			if (err_q < 0) begin
				err_q <= err_q + job_q.inc_lt;
			end else begin
				err_q   <= err_q + job_q.inc_ge;
				minor_q <= minor_q + 1'b1;
			end
			for (int c = 0; c < NUM_CHAN; c++) begin
				acc_q[c]  <= acc_d[c];
				frac_q[c] <= frac_d[c];
			end
		end
		if (emit) begin
			pixel_q <= pixel_d;
		end
	end

	a_active_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> remaining_q != '0)
		else $error("walker active with no pixels left");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last |=> !active_q && out_valid_q && pixel_q.last_pixel)
		else $error("walk did not end on its last pixel");

	a_blend_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> frac_ok)
		else $error("blend remainder reached the span");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !(emit && last) |=> !$rose(pixel_q.last_pixel) || active_q == 1'b0 ||
			$past(last))
		else $error("segment boundary lost");

endmodule

[rtl/gradient_line_rasterizer.sv]
// Line rasterizer with a per-channel color blend between the two endpoints.
// Segments enter through a queue-style port: a segment transfers on a clock
// edge with push high and full low. Pixels leave the same way: while empty is
// low the oldest pixel is on the pixel port, and it transfers on an edge with
// pop high. Each segment yields one pixel per major-axis step, at most 64,
// and the final one carries last_pixel. A segment whose end does not lie past
// its start along the major axis yields no pixel at all.
// The front end takes one segment, runs it through a bit-serial divider per
// channel that splits the color delta by the span, and hands the job to a
// two-entry queue; full stays high while it divides and until the queue takes
// the job, so it takes no new segment before it is through with the last. The
// back end loads a job from the queue and then emits one pixel per cycle while
// the pixel side keeps up. The front end works on the next segment while the
// back end walks. When the pixel side stalls, the walker holds and the queue
// and then full push back on the segment side.
// The user must write the color and pad registers through cfg_wr_en,
// cfg_index and cfg_data only while the block is idle; the block itself does
// not enforce this. Reset empties the queue and output stage and restores the
// register defaults.
module gradient_line_rasterizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  glr_pkg::segment_t                segment,
	output logic                             empty,
	input  logic                             pop,
	output glr_pkg::pixel_t                  pixel,
	input  logic                             cfg_wr_en,
	input  logic [glr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [glr_pkg::COLOR_BITS-1:0]   cfg_data
);
	import glr_pkg::*;

	logic [COLOR_BITS-1:0]  flat_color_q, raised_color_q;
	logic [OFFSET_BITS-1:0] pixel_offset_q;

	logic q_wr, q_full, q_rd, q_empty;
	job_t wr_job, rd_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_color_q   <= FLAT_COLOR_RESET;
			raised_color_q <= RAISED_COLOR_RESET;
			pixel_offset_q <= PIXEL_OFFSET_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FLAT_COLOR:   flat_color_q   <= cfg_data;
				REG_RAISED_COLOR: raised_color_q <= cfg_data;
				REG_PIXEL_OFFSET: pixel_offset_q <= cfg_data[OFFSET_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	glr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.segment      (segment),
		.flat_color   (flat_color_q),
		.raised_color (raised_color_q),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_job        (wr_job)
	);

	glr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_job (wr_job),
		.full   (q_full),
		.rd     (q_rd),
		.rd_job (rd_job),
		.empty  (q_empty)
	);

	glr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_rd         (q_rd),
		.q_job        (rd_job),
		.pixel_offset (pixel_offset_q),
		.empty        (empty),
		.pop          (pop),
		.pixel        (pixel)
	);

endmodule
